### rtl/tcc_pkg.sv
// Shared types, codes and helper functions of the text console cursor control.
package tcc_pkg;

  // Grid limits and field widths
  localparam int unsigned MAX_COLS  = 128;
  localparam int unsigned MAX_ROWS  = 64;
  localparam int unsigned COL_W     = 7;
  localparam int unsigned ROW_W     = 6;
  localparam int unsigned COLS_W    = 8;
  localparam int unsigned ROWS_W    = 7;
  localparam int unsigned TAB_STOP  = 8;
  localparam int unsigned VT_STOP   = 6;
  localparam int unsigned VT_CNT_W  = 3;
  localparam int unsigned CFG_IDX_W = 1;
  localparam int unsigned CFG_DAT_W = 8;

  // Register reset values
  localparam logic [COLS_W-1:0] COLS_RESET = 8'd80;
  localparam logic [ROWS_W-1:0] ROWS_RESET = 7'd25;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_COLUMN_COUNT = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_ROW_COUNT    = 1'b1;

  // Control character codes
  localparam logic [7:0] CH_BELL  = 8'd7;
  localparam logic [7:0] CH_BS    = 8'd8;
  localparam logic [7:0] CH_HT    = 8'd9;
  localparam logic [7:0] CH_LF    = 8'd10;
  localparam logic [7:0] CH_VT    = 8'd11;
  localparam logic [7:0] CH_FF    = 8'd12;
  localparam logic [7:0] CH_CR    = 8'd13;
  localparam logic [7:0] CH_SPACE = 8'd32;

  // Classified operation passed from front to back
  typedef enum logic [2:0] {
    OP_PRINT,
    OP_BELL,
    OP_BS,
    OP_TAB,
    OP_LF,
    OP_VT,
    OP_FF,
    OP_CR
  } op_e;

  typedef struct packed {
    op_e        op;
    logic [7:0] glyph;
  } cmd_t;

  // Result kinds
  typedef enum logic [1:0] {
    KIND_NONE  = 2'd0,
    KIND_WRITE = 2'd1,
    KIND_CLEAR = 2'd2,
    KIND_BELL  = 2'd3
  } kind_e;

  typedef struct packed {
    logic [1:0]       kind;
    logic [COL_W-1:0] cell_col;
    logic [ROW_W-1:0] cell_row;
    logic [7:0]       glyph;
    logic [COL_W-1:0] cursor_col_out;
    logic [ROW_W-1:0] cursor_row_out;
    logic             last;
  } res_t;

  // Move down one row, wrapping to row 0 at the bottom of the grid
  function automatic logic [ROW_W-1:0] step_row(input logic [ROW_W-1:0]  row,
                                                input logic [ROWS_W-1:0] rows);
    logic [ROW_W-1:0] nxt;
    nxt = row + ROW_W'(1);
    if (({1'b0, nxt} >= rows) || (nxt == '0)) begin
      step_row = '0;
    end else begin
      step_row = nxt;
    end
  endfunction

  // True when the row sits on a vertical tab stop
  function automatic logic on_vt_stop(input logic [ROW_W-1:0] row);
    logic hit;
    hit = 1'b0;
    for (int k = 0; k * VT_STOP < (1 << ROW_W); k++) begin
      if (row == ROW_W'(k * VT_STOP)) hit = 1'b1;
    end
    on_vt_stop = hit;
  endfunction

endpackage

### rtl/tcc_if.sv
// Valid/ready channel interfaces for characters, results and configuration writes.
interface tcc_char_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_code;

  modport source (output valid, output char_code, input ready);
  modport sink   (input valid, input char_code, output ready);
endinterface

interface tcc_res_if;
  logic       valid;
  logic       ready;
  logic [1:0] kind;
  logic [6:0] cell_col;
  logic [5:0] cell_row;
  logic [7:0] glyph;
  logic [6:0] cursor_col_out;
  logic [5:0] cursor_row_out;
  logic       last;

  modport source (output valid, output kind, output cell_col, output cell_row, output glyph,
                  output cursor_col_out, output cursor_row_out, output last, input ready);
  modport sink   (input valid, input kind, input cell_col, input cell_row, input glyph,
                  input cursor_col_out, input cursor_row_out, input last, output ready);
endinterface

interface tcc_cfg_if;
  logic       valid;
  logic       ready;
  logic [0:0] index;
  logic [7:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

### rtl/tcc_front.sv
// Front end: accepts character transfers and classifies them into commands.
module tcc_front (
  tcc_char_if.sink      char_i,
  output logic          push_valid_o,
  output tcc_pkg::cmd_t push_cmd_o,
  input  logic          push_ready_i
);
  import tcc_pkg::*;

  // Pass the handshake through to the queue
  assign push_valid_o = char_i.valid;
  assign char_i.ready = push_ready_i;

  // Classify the character code
  always_comb begin
    push_cmd_o.glyph = char_i.char_code;
    unique case (char_i.char_code)
      CH_BELL: push_cmd_o.op = OP_BELL;
      CH_BS:   push_cmd_o.op = OP_BS;
      CH_HT: begin
        push_cmd_o.op    = OP_TAB;
        push_cmd_o.glyph = CH_SPACE;
      end
      CH_LF:   push_cmd_o.op = OP_LF;
      CH_VT:   push_cmd_o.op = OP_VT;
      CH_FF:   push_cmd_o.op = OP_FF;
      CH_CR:   push_cmd_o.op = OP_CR;
      default: push_cmd_o.op = OP_PRINT;
    endcase
  end

endmodule

### rtl/tcc_queue.sv
// Two-entry command queue between the front end and the sequencer.
module tcc_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_valid_i,
  input  tcc_pkg::cmd_t push_cmd_i,
  output logic          push_ready_o,
  output logic          pop_valid_o,
  output tcc_pkg::cmd_t pop_cmd_o,
  input  logic          pop_ready_i
);
  import tcc_pkg::*;

  cmd_t       mem_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] count_q, count_d;
  logic       push, pop;

  assign push_ready_o = (count_q != 2'd2);
  assign pop_valid_o  = (count_q != 2'd0);
  assign pop_cmd_o    = mem_q[rd_ptr_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  // Advance pointers and fill level
  always_comb begin
    wr_ptr_d = wr_ptr_q ^ push;
    rd_ptr_d = rd_ptr_q ^ pop;
    count_d  = count_q + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Store entries
  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_cmd_i;
    end
  end

endmodule

### rtl/tcc_back.sv
// Back end: cursor sequencer, configuration registers and result output register.
module tcc_back (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          pop_valid_i,
  input  tcc_pkg::cmd_t pop_cmd_i,
  output logic          pop_ready_o,
  tcc_cfg_if.sink       cfg_i,
  tcc_res_if.source     res_o
);
  import tcc_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_WRITE = 4'b0010,
    S_LF    = 4'b0100,
    S_VT    = 4'b1000
  } state_e;

  state_e              state_q, state_d;
  logic [COL_W-1:0]    cursor_col_q, cursor_col_d;
  logic [ROW_W-1:0]    cursor_row_q, cursor_row_d;
  logic [7:0]          glyph_q, glyph_d;
  logic                tab_q, tab_d;
  logic [VT_CNT_W-1:0] vt_cnt_q, vt_cnt_d;
  logic [COLS_W-1:0]   cols_q;
  logic [ROWS_W-1:0]   rows_q;
  logic                res_valid_q, res_valid_d;
  res_t                res_q, res_d;
  logic                out_free;
  logic [COLS_W-1:0]   next_col;
  logic [COLS_W-1:0]   bs_col;

  assign out_free    = !res_valid_q || res_o.ready;
  assign next_col    = {1'b0, cursor_col_q} + COLS_W'(1);
  assign bs_col      = {1'b0, cursor_col_q} - COLS_W'(1);
  assign pop_ready_o = (state_q == S_IDLE) && out_free;
  assign cfg_i.ready = 1'b1;

  // Clamp configuration writes into the supported grid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cols_q <= COLS_RESET;
      rows_q <= ROWS_RESET;
    end else if (cfg_i.valid) begin
      unique case (cfg_i.index)
        CFG_COLUMN_COUNT: begin
          if (cfg_i.data == '0) cols_q <= COLS_W'(1);
          else if (cfg_i.data > COLS_W'(MAX_COLS)) cols_q <= COLS_W'(MAX_COLS);
          else cols_q <= cfg_i.data;
        end
        CFG_ROW_COUNT: begin
          if (cfg_i.data[ROWS_W-1:0] == '0) rows_q <= ROWS_W'(1);
          else if (cfg_i.data[ROWS_W-1:0] > ROWS_W'(MAX_ROWS)) rows_q <= ROWS_W'(MAX_ROWS);
          else rows_q <= cfg_i.data[ROWS_W-1:0];
        end
        default: ;
      endcase
    end
  end

  // Sequence one command at a time
  always_comb begin
    state_d      = state_q;
    cursor_col_d = cursor_col_q;
    cursor_row_d = cursor_row_q;
    glyph_d      = glyph_q;
    tab_d        = tab_q;
    vt_cnt_d     = vt_cnt_q;
    res_valid_d  = res_valid_q && !res_o.ready;
    res_d        = res_q;

    unique case (state_q)
      S_IDLE: begin
        if (pop_valid_i && out_free) begin
          res_d       = '0;
          res_d.kind  = KIND_NONE;
          res_d.last  = 1'b1;
          unique case (pop_cmd_i.op)
            OP_BELL: begin
              res_valid_d = 1'b1;
              res_d.kind  = KIND_BELL;
            end
            OP_BS: begin
              res_valid_d = 1'b1;
              if (cursor_col_q == '0) cursor_col_d = '0;
              else if (bs_col >= cols_q) cursor_col_d = COL_W'(cols_q - COLS_W'(1));
              else cursor_col_d = bs_col[COL_W-1:0];
              if ({1'b0, cursor_row_q} >= rows_q) begin
                cursor_row_d = ROW_W'(rows_q - ROWS_W'(1));
              end
            end
            OP_LF: begin
              res_valid_d    = 1'b1;
              cursor_col_d   = '0;
              cursor_row_d   = step_row(cursor_row_q, rows_q);
              res_d.kind     = KIND_CLEAR;
              res_d.cell_row = cursor_row_d;
            end
            OP_FF: begin
              res_valid_d  = 1'b1;
              cursor_row_d = step_row(cursor_row_q, rows_q);
            end
            OP_CR: begin
              res_valid_d  = 1'b1;
              cursor_col_d = '0;
            end
            OP_VT: begin
              vt_cnt_d = '0;
              state_d  = S_VT;
            end
            OP_TAB, OP_PRINT: begin
              glyph_d = pop_cmd_i.glyph;
              tab_d   = (pop_cmd_i.op == OP_TAB);
              state_d = S_WRITE;
            end
            default: ;
          endcase
          res_d.cursor_col_out = cursor_col_d;
          res_d.cursor_row_out = cursor_row_d;
        end
      end

      // Write a cell and advance; a wrap hands over to the line feed result
      S_WRITE: begin
        if (out_free) begin
          res_valid_d    = 1'b1;
          res_d          = '0;
          res_d.kind     = KIND_WRITE;
          res_d.cell_col = cursor_col_q;
          res_d.cell_row = cursor_row_q;
          res_d.glyph    = glyph_q;
          if (next_col >= cols_q) begin
            cursor_col_d = '0;
            cursor_row_d = step_row(cursor_row_q, rows_q);
            res_d.last   = 1'b0;
            state_d      = S_LF;
          end else begin
            cursor_col_d = next_col[COL_W-1:0];
            res_d.last   = !tab_q || (next_col[2:0] == '0);
            if (res_d.last) state_d = S_IDLE;
          end
          res_d.cursor_col_out = cursor_col_d;
          res_d.cursor_row_out = cursor_row_d;
        end
      end

      S_LF: begin
        if (out_free) begin
          res_valid_d          = 1'b1;
          res_d                = '0;
          res_d.kind           = KIND_CLEAR;
          res_d.cell_row       = cursor_row_q;
          res_d.cursor_col_out = cursor_col_q;
          res_d.cursor_row_out = cursor_row_q;
          res_d.last           = 1'b1;
          state_d              = S_IDLE;
        end
      end

      // Step one row per cycle until a vertical tab stop, at most VT_STOP steps
      S_VT: begin
        if ((vt_cnt_q < VT_CNT_W'(VT_STOP)) && !on_vt_stop(cursor_row_q)) begin
          cursor_row_d = step_row(cursor_row_q, rows_q);
          vt_cnt_d     = vt_cnt_q + VT_CNT_W'(1);
        end else if (out_free) begin
          res_valid_d          = 1'b1;
          res_d                = '0;
          res_d.kind           = KIND_NONE;
          res_d.cursor_col_out = cursor_col_q;
          res_d.cursor_row_out = cursor_row_q;
          res_d.last           = 1'b1;
          state_d              = S_IDLE;
        end
      end

      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      cursor_col_q <= '0;
      cursor_row_q <= '0;
      res_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      cursor_col_q <= cursor_col_d;
      cursor_row_q <= cursor_row_d;
      res_valid_q  <= res_valid_d;
    end
  end

  // Hold payload and command context
  always_ff @(posedge clk_i) begin
    glyph_q  <= glyph_d;
    tab_q    <= tab_d;
    vt_cnt_q <= vt_cnt_d;
    res_q    <= res_d;
  end

  // Drive the result channel from the output register
  assign res_o.valid          = res_valid_q;
  assign res_o.kind           = res_q.kind;
  assign res_o.cell_col       = res_q.cell_col;
  assign res_o.cell_row       = res_q.cell_row;
  assign res_o.glyph          = res_q.glyph;
  assign res_o.cursor_col_out = res_q.cursor_col_out;
  assign res_o.cursor_row_out = res_q.cursor_row_out;
  assign res_o.last           = res_q.last;

endmodule

### rtl/text_console_cursor_control.sv
// Top level of the text console cursor control: front end, command queue, sequencer.
// Bell, backspace, line feed, form feed and carriage return give their result through the queue
// entry and the output register; printable codes and tabs also pass the write state, and a
// vertical tab steps its rows first. The sequencer takes those five codes back to back while the
// output is free; a printable code or tab holds it for each result, a vertical tab for its row steps.
// Reset clears the cursor, the queue and the output register; sizes return to 80 x 25.
module text_console_cursor_control (
  input  logic      clk_i,
  input  logic      rst_ni,
  tcc_char_if.sink  char_i,
  tcc_cfg_if.sink   cfg_i,
  tcc_res_if.source res_o
);
  import tcc_pkg::*;

  logic push_valid, push_ready;
  cmd_t push_cmd;
  logic pop_valid, pop_ready;
  cmd_t pop_cmd;

  // Accept and classify characters
  tcc_front u_front (
    .char_i       (char_i),
    .push_valid_o (push_valid),
    .push_cmd_o   (push_cmd),
    .push_ready_i (push_ready)
  );

  // Decouple front and back
  tcc_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_cmd_i   (push_cmd),
    .push_ready_o (push_ready),
    .pop_valid_o  (pop_valid),
    .pop_cmd_o    (pop_cmd),
    .pop_ready_i  (pop_ready)
  );

  // Carry out commands and emit results
  tcc_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .pop_valid_i (pop_valid),
    .pop_cmd_i   (pop_cmd),
    .pop_ready_o (pop_ready),
    .cfg_i       (cfg_i),
    .res_o       (res_o)
  );

endmodule

### sim/tb_text_console_cursor_control.sv
// Self-checking testbench for the text console cursor control: scoreboard against a cursor model.
module tb_text_console_cursor_control;
  import tcc_pkg::*;

  localparam int HALF_PERIOD   = 6;
  localparam int CYCLE_LIMIT   = 1000000;
  localparam int HOLD_AT       = 150;
  localparam int HOLD_CYCLES   = 400;
  localparam int SETTLE_CYCLES = 12;
  localparam int MAX_RESULTS   = 9;
  localparam int RAND_PHASES   = 8;
  localparam int PHASE_CHARS   = 60;
  localparam int REPORT_LIMIT  = 10;

  typedef struct packed {
    kind_e            kind;
    logic [COL_W-1:0] cell_col;
    logic [ROW_W-1:0] cell_row;
    logic [7:0]       glyph;
    logic [COL_W-1:0] cursor_col_out;
    logic [ROW_W-1:0] cursor_row_out;
    logic             last;
  } cell_action_t;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  // Locally held drive values, known from time zero
  logic                 char_valid = 1'b0;
  logic [7:0]           char_code  = '0;
  logic                 cfg_valid  = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index  = '0;
  logic [CFG_DAT_W-1:0] cfg_data   = '0;
  logic                 res_ready  = 1'b0;

  tcc_char_if char_ch();
  tcc_cfg_if  cfg_ch();
  tcc_res_if  res_ch();

  assign char_ch.valid     = char_valid;
  assign char_ch.char_code = char_code;
  assign cfg_ch.valid      = cfg_valid;
  assign cfg_ch.index      = cfg_index;
  assign cfg_ch.data       = cfg_data;
  assign res_ch.ready      = res_ready;

  text_console_cursor_control u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .char_i (char_ch),
    .cfg_i  (cfg_ch),
    .res_o  (res_ch)
  );

  always #HALF_PERIOD clk_i = ~clk_i;

  // Cursor model state and its register copies
  logic [COLS_W-1:0] grid_cols = COLS_RESET;
  logic [ROWS_W-1:0] grid_rows = ROWS_RESET;
  logic [COL_W-1:0]  cur_col   = '0;
  logic [ROW_W-1:0]  cur_row   = '0;
  cell_action_t      expected_results[$];
  cell_action_t      burst[MAX_RESULTS];
  int                burst_len;

  logic [7:0] pending_chars[$];
  logic       calm           = 1'b0;
  int         send_gap       = 0;
  int         stall_left     = 0;
  int         hold_left      = 0;
  logic       hold_done      = 1'b0;
  int         chars_accepted = 0;
  int         results_seen   = 0;
  int         mismatches     = 0;
  int         cycle_count    = 0;

  function automatic int active_cols();
    int c;
    c = int'(grid_cols);
    if (c < 1) c = 1;
    if (c > int'(MAX_COLS)) c = int'(MAX_COLS);
    return c;
  endfunction

  function automatic int active_rows();
    int r;
    r = int'(grid_rows);
    if (r < 1) r = 1;
    if (r > int'(MAX_ROWS)) r = int'(MAX_ROWS);
    return r;
  endfunction

  // Move down one row, wrapping to the top at the bottom of the grid
  function automatic logic [ROW_W-1:0] row_below(input logic [ROW_W-1:0] row);
    logic [ROW_W-1:0] nxt;
    nxt = row + 1'b1;
    if (int'(nxt) >= active_rows() || nxt == '0) nxt = '0;
    return nxt;
  endfunction

  // Record one result with the cursor as it now stands
  task automatic note_result(input kind_e kind, input logic [COL_W-1:0] col,
                             input logic [ROW_W-1:0] row, input logic [7:0] glyph);
    cell_action_t r;
    r.kind           = kind;
    r.cell_col       = col;
    r.cell_row       = row;
    r.glyph          = glyph;
    r.cursor_col_out = cur_col;
    r.cursor_row_out = cur_row;
    r.last           = 1'b0;
    if (burst_len < MAX_RESULTS) begin
      burst[burst_len] = r;
      burst_len++;
    end
  endtask

  // Write one glyph at the cursor and advance, wrapping with a line feed
  task automatic put_glyph(input logic [7:0] g);
    logic [COL_W-1:0] at_col;
    logic [ROW_W-1:0] at_row;
    at_col = cur_col;
    at_row = cur_row;
    if (int'(cur_col) + 1 >= active_cols()) begin
      cur_col = '0;
      cur_row = row_below(cur_row);
      note_result(KIND_WRITE, at_col, at_row, g);
      note_result(KIND_CLEAR, '0, cur_row, 8'h00);
    end else begin
      cur_col = cur_col + 1'b1;
      note_result(KIND_WRITE, at_col, at_row, g);
    end
  endtask

  // Work out the results of one character and queue them
  task automatic track_cursor(input logic [7:0] code);
    burst_len = 0;
    case (code)
      CH_BELL: note_result(KIND_BELL, '0, '0, 8'h00);
      CH_BS: begin
        if (cur_col != '0) begin
          if (int'(cur_col) - 1 >= active_cols()) cur_col = COL_W'(active_cols() - 1);
          else cur_col = cur_col - 1'b1;
        end
        if (int'(cur_row) >= active_rows()) cur_row = ROW_W'(active_rows() - 1);
        note_result(KIND_NONE, '0, '0, 8'h00);
      end
      CH_HT: begin
        if (cur_col[2:0] == 3'd0) put_glyph(CH_SPACE);
        for (int i = 0; i < int'(TAB_STOP) && cur_col[2:0] != 3'd0; i++) put_glyph(CH_SPACE);
      end
      CH_LF: begin
        cur_col = '0;
        cur_row = row_below(cur_row);
        note_result(KIND_CLEAR, '0, cur_row, 8'h00);
      end
      CH_VT: begin
        for (int i = 0; i < int'(VT_STOP) && (cur_row % VT_STOP) != 0; i++)
          cur_row = row_below(cur_row);
        note_result(KIND_NONE, '0, '0, 8'h00);
      end
      CH_FF: begin
        cur_row = row_below(cur_row);
        note_result(KIND_NONE, '0, '0, 8'h00);
      end
      CH_CR: begin
        cur_col = '0;
        note_result(KIND_NONE, '0, '0, 8'h00);
      end
      default: put_glyph(code);
    endcase
    burst[burst_len-1].last = 1'b1;
    for (int i = 0; i < burst_len; i++) expected_results.push_back(burst[i]);
  endtask

  function automatic string show(input cell_action_t a);
    return $sformatf("kind=%0d col=%0d row=%0d glyph=%0d cursor=(%0d,%0d) last=%0d",
                     a.kind, a.cell_col, a.cell_row, a.glyph, a.cursor_col_out,
                     a.cursor_row_out, a.last);
  endfunction

  // Character driver: predict on each transfer, then offer the next item or idle
  always @(posedge clk_i) begin
    if (char_valid && char_ch.ready) begin
      track_cursor(char_code);
      chars_accepted <= chars_accepted + 1;
    end
    if (!rst_ni) begin
      char_valid <= 1'b0;
    end else if (!char_valid || char_ch.ready) begin
      if (send_gap > 0) begin
        send_gap   <= send_gap - 1;
        char_valid <= 1'b0;
      end else if (pending_chars.size() != 0) begin
        char_code  <= pending_chars.pop_front();
        char_valid <= 1'b1;
        if (!calm && $urandom_range(0, 7) == 0) send_gap <= $urandom_range(1, 17);
      end else begin
        char_valid <= 1'b0;
      end
    end
  end

  // Result monitor: compare each transfer with the oldest expectation, then set ready
  always @(posedge clk_i) begin
    cell_action_t got;
    cell_action_t want;
    if (res_ch.valid && res_ready) begin
      got = {kind_e'(res_ch.kind), res_ch.cell_col, res_ch.cell_row, res_ch.glyph,
             res_ch.cursor_col_out, res_ch.cursor_row_out, res_ch.last};
      results_seen <= results_seen + 1;
      if (expected_results.size() == 0) begin
        mismatches <= mismatches + 1;
        if (mismatches < REPORT_LIMIT) $display("Unexpected result: %s", show(got));
      end else begin
        want = expected_results.pop_front();
        if (got.kind !== want.kind || got.cell_col !== want.cell_col ||
            got.cell_row !== want.cell_row || got.glyph !== want.glyph ||
            got.cursor_col_out !== want.cursor_col_out ||
            got.cursor_row_out !== want.cursor_row_out || got.last !== want.last) begin
          mismatches <= mismatches + 1;
          if (mismatches < REPORT_LIMIT) begin
            $display("Mismatch expected: %s", show(want));
            $display("         actual:   %s", show(got));
          end
        end
      end
    end
    if (!rst_ni) begin
      res_ready <= 1'b0;
    end else if (hold_left != 0) begin
      res_ready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      res_ready  <= 1'b0;
    end else begin
      res_ready <= 1'b1;
      if (!calm && $urandom_range(0, 9) == 0) stall_left <= $urandom_range(1, 17);
    end
  end

  // Hold the result side off once for a long stretch so the input backs up
  always @(posedge clk_i) begin
    if (!hold_done && chars_accepted == HOLD_AT) begin
      hold_left <= HOLD_CYCLES;
      hold_done <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // Abort a hung run
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  task automatic send(input logic [7:0] code);
    pending_chars.push_back(code);
  endtask

  // Wait until every character is taken and every result is back, then settle
  task automatic drain();
    do @(negedge clk_i);
    while (pending_chars.size() != 0 || char_valid || expected_results.size() != 0);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DAT_W-1:0] value);
    @(posedge clk_i);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk_i);
    while (!cfg_ch.ready);
    if (idx == CFG_COLUMN_COUNT) grid_cols = value[COLS_W-1:0];
    else grid_rows = value[ROWS_W-1:0];
    cfg_valid <= 1'b0;
    @(negedge clk_i);
  endtask

  function automatic logic [7:0] pick_char();
    int r;
    r = $urandom_range(0, 99);
    if (r < 40) return 8'($urandom_range(32, 126));
    else if (r < 70) return 8'($urandom_range(int'(CH_BELL), int'(CH_CR)));
    else if (r < 80) return CH_HT;
    else return 8'($urandom_range(0, 255));
  endfunction

  // Stimulus: directed sequence, then random phases under changing grid sizes
  initial begin
    logic [7:0] col_choices[10];
    logic [7:0] row_choices[10];
    int         settings;
    int         chars_total;
    col_choices = '{8'd0, 8'd1, 8'd2, 8'd7, 8'd8, 8'd9, 8'd80, 8'd127, 8'd128, 8'd255};
    row_choices = '{8'd0, 8'd1, 8'd2, 8'd5, 8'd6, 8'd7, 8'd25, 8'd63, 8'd64, 8'd255};
    settings    = 1;
    chars_total = 0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Default grid: byte extremes, tabs on and off a stop, each control code
    send(8'h00); send(8'hFF); send(8'h41); send(CH_BELL); send(CH_BS);
    send(CH_HT); send(CH_HT); send(CH_CR); send(CH_BS); send(CH_LF);
    send(CH_VT); send(CH_FF); send(8'h80); send(8'h7F); send(8'd6);
    send(8'd14); send(8'd31); send(CH_SPACE);
    chars_total += 18;
    drain();

    // Oversized column count, zero row count; cursor sits below the grid
    write_reg(CFG_COLUMN_COUNT, 8'd255);
    write_reg(CFG_ROW_COUNT, 8'd0);
    settings++;
    send(8'h7A); send(CH_FF);
    chars_total += 2;
    drain();

    // Zero columns: backspace clamps into the grid, every write wraps
    write_reg(CFG_COLUMN_COUNT, 8'd0);
    write_reg(CFG_ROW_COUNT, 8'd64);
    settings++;
    send(CH_BS); send(8'h71); send(CH_HT);
    chars_total += 3;
    drain();

    // Narrow single-row grid: a tab from column zero fills the row and wraps
    write_reg(CFG_COLUMN_COUNT, 8'd8);
    write_reg(CFG_ROW_COUNT, 8'd1);
    settings++;
    send(CH_HT);
    chars_total += 1;
    drain();

    for (int p = 0; p < RAND_PHASES; p++) begin
      if ($urandom_range(0, 1) == 0)
        write_reg(CFG_COLUMN_COUNT, col_choices[$urandom_range(0, 9)]);
      else
        write_reg(CFG_COLUMN_COUNT, 8'($urandom_range(1, 128)));
      if ($urandom_range(0, 1) == 0)
        write_reg(CFG_ROW_COUNT, row_choices[$urandom_range(0, 9)]);
      else
        write_reg(CFG_ROW_COUNT, 8'($urandom_range(1, 64)));
      settings++;
      // No idling in the closing phase
      if (p == RAND_PHASES - 1) calm = 1'b1;
      for (int i = 0; i < PHASE_CHARS; i++) send(pick_char());
      chars_total += PHASE_CHARS;
      drain();
    end

    $display("Covered %0d characters under %0d grid settings, %0d results compared",
             chars_total, settings, results_seen);
    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Mismatches: %0d, results still outstanding: %0d", mismatches,
               expected_results.size());
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

### text_console_cursor_control.f
rtl/tcc_pkg.sv
rtl/tcc_if.sv
rtl/tcc_front.sv
rtl/tcc_queue.sv
rtl/tcc_back.sv
rtl/text_console_cursor_control.sv
sim/tb_text_console_cursor_control.sv
